/* rtl/core/llws_pkg.sv */
// ----------------------------------------------------------------------------
// llws_pkg: shared types and constants for the worker selector
// Command and state codes, register indexes, field widths and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package llws_pkg;

    // Default number of worker slots
    localparam int ACTOR_SLOTS_DEF = 16;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int ID_W     = 4;
    localparam int TIME_W   = 32;
    localparam int USAGE_W  = 7;
    localparam int LEVEL_W  = 3;
    localparam int WEIGHT_W = 4;
    localparam int LOAD_W   = 13;
    localparam int WINDOW_W = 8;
    localparam int PROD_W   = USAGE_W + WEIGHT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Overload thresholds
    localparam logic [USAGE_W-1:0] CPU_LIMIT  = 7'd80;
    localparam logic [USAGE_W-1:0] MEM_LIMIT  = 7'd80;
    localparam logic [USAGE_W-1:0] DISK_LIMIT = 7'd90;

    // Register reset values
    localparam logic [WEIGHT_W-1:0] CPU_WEIGHT_RST  = 4'd1;
    localparam logic [WEIGHT_W-1:0] MEM_WEIGHT_RST  = 4'd1;
    localparam logic [WEIGHT_W-1:0] DISK_WEIGHT_RST = 4'd0;
    localparam logic [LOAD_W-1:0]   MAX_LOAD_RST    = 13'd160;
    localparam logic [LOAD_W-1:0]   LOW_LOAD_RST    = 13'd40;
    localparam logic [WINDOW_W-1:0] WINDOW_RST      = 8'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_CONNECT    = 3'd0,
        CMD_REPORT     = 3'd1,
        CMD_DISCONNECT = 3'd2,
        CMD_REMOVE     = 3'd3,
        CMD_SELECT     = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPU_WEIGHT  = 3'd0,
        CFG_MEM_WEIGHT  = 3'd1,
        CFG_DISK_WEIGHT = 3'd2,
        CFG_MAX_LOAD    = 3'd3,
        CFG_LOW_LOAD    = 3'd4,
        CFG_WINDOW      = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DES_EV,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // One slot's reported usage, held in the usage memory
    typedef struct packed {
        logic [USAGE_W-1:0] cpu;
        logic [USAGE_W-1:0] mem;
        logic [USAGE_W-1:0] disk;
        logic [LEVEL_W-1:0] level;
    } usage_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;       // latch the input beat
        logic update;        // apply a table command
        logic issue_desired; // read the desired slot
        logic eval_desired;  // judge the desired slot
        logic scan_init;     // restart the scan
        logic issue_scan;    // read the next scan slot
        logic eval_scan;     // judge the slot read last cycle
        logic out_load;      // move the result to the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_select;
        logic use_desired;
        logic desired_hit;
        logic scan_last;
        logic stop;
    } dp_status_t;

endpackage

/* rtl/core/llws_dp.sv */
// ----------------------------------------------------------------------------
// llws_dp: worker table and load evaluation datapath
// Holds the slot flags, usage and report-time memories, the configuration
// registers, the scan counter, the running best and the output register.
// ----------------------------------------------------------------------------
module llws_dp #(
    parameter int ACTOR_SLOTS = llws_pkg::ACTOR_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  llws_pkg::dp_cmd_t                   ctl,
    output llws_pkg::dp_status_t                sts,
    input  logic [llws_pkg::CMD_W-1:0]          command,
    input  logic [llws_pkg::ID_W-1:0]           actor_id,
    input  logic                                has_desired,
    input  logic [llws_pkg::TIME_W-1:0]         now,
    input  logic [llws_pkg::USAGE_W-1:0]        cpu_usage,
    input  logic [llws_pkg::USAGE_W-1:0]        mem_usage,
    input  logic [llws_pkg::USAGE_W-1:0]        disk_usage,
    input  logic [llws_pkg::LEVEL_W-1:0]        worker_level,
    input  logic [llws_pkg::LEVEL_W-1:0]        priority_req,
    input  logic                                cfg_we,
    input  logic [llws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [llws_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                found,
    output logic [llws_pkg::ID_W-1:0]           chosen_actor,
    output logic [llws_pkg::LOAD_W-1:0]         chosen_load,
    output logic                                status
);

    localparam int SLOT_W = $clog2(ACTOR_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ACTOR_SLOTS - 1);

    // Configuration registers
    logic [llws_pkg::WEIGHT_W-1:0] cpu_weight_reg;
    logic [llws_pkg::WEIGHT_W-1:0] mem_weight_reg;
    logic [llws_pkg::WEIGHT_W-1:0] disk_weight_reg;
    logic [llws_pkg::LOAD_W-1:0]   max_load_reg;
    logic [llws_pkg::LOAD_W-1:0]   low_load_reg;
    logic [llws_pkg::WINDOW_W-1:0] window_reg;

    // Captured input beat
    llws_pkg::cmd_t                cmd_reg;
    logic [llws_pkg::ID_W-1:0]     id_reg;
    logic                          des_reg;
    logic [llws_pkg::TIME_W-1:0]   now_reg;
    llws_pkg::usage_t              rep_reg;
    logic [llws_pkg::LEVEL_W-1:0]  prio_reg;

    // Slot flags
    logic [ACTOR_SLOTS-1:0] slot_valid_reg;
    logic [ACTOR_SLOTS-1:0] link_ok_reg;
    logic [ACTOR_SLOTS-1:0] usage_known_reg;

    // Slot memories
    llws_pkg::usage_t            usage_mem [ACTOR_SLOTS];
    logic [llws_pkg::TIME_W-1:0] time_mem  [ACTOR_SLOTS];
    llws_pkg::usage_t            usage_rd_reg;
    logic [llws_pkg::TIME_W-1:0] time_rd_reg;

    // Scan state
    logic [SLOT_W-1:0]         scan_addr_reg;
    logic [SLOT_W-1:0]         ev_idx_reg;
    logic                      pend_valid_reg;
    logic [llws_pkg::LOAD_W-1:0] best_reg;

    // Result and output registers
    logic                        res_found_reg;
    logic [llws_pkg::ID_W-1:0]   res_actor_reg;
    logic [llws_pkg::LOAD_W-1:0] res_load_reg;
    logic                        res_status_reg;
    logic                        found_reg;
    logic [llws_pkg::ID_W-1:0]   actor_reg;
    logic [llws_pkg::LOAD_W-1:0] load_reg;
    logic                        status_reg;

    logic                        id_in_range;
    logic [SLOT_W-1:0]           id_idx;
    logic                        present;
    logic                        rd_en;
    logic [SLOT_W-1:0]           rd_addr;
    logic [llws_pkg::PROD_W-1:0] prod_cpu;
    logic [llws_pkg::PROD_W-1:0] prod_mem;
    logic [llws_pkg::PROD_W-1:0] prod_disk;
    logic [llws_pkg::LOAD_W-1:0] load_sum;
    logic                        overload;
    logic [llws_pkg::TIME_W-1:0] age;
    logic                        eligible;
    logic [llws_pkg::LOAD_W-1:0] bound;
    logic                        cand_ok;

    assign id_in_range = (32'(id_reg) < 32'(ACTOR_SLOTS));
    assign id_idx      = SLOT_W'(id_reg);
    assign present     = id_in_range && slot_valid_reg[id_idx];

    assign rd_en   = ctl.issue_desired || ctl.issue_scan;
    assign rd_addr = ctl.issue_desired ? id_idx : scan_addr_reg;

    // Load and eligibility of the slot read last cycle
    assign prod_cpu  = llws_pkg::PROD_W'(usage_rd_reg.cpu) * llws_pkg::PROD_W'(cpu_weight_reg);
    assign prod_mem  = llws_pkg::PROD_W'(usage_rd_reg.mem) * llws_pkg::PROD_W'(mem_weight_reg);
    assign prod_disk = llws_pkg::PROD_W'(usage_rd_reg.disk)
                     * llws_pkg::PROD_W'(disk_weight_reg);
    assign load_sum  = llws_pkg::LOAD_W'(prod_cpu) + llws_pkg::LOAD_W'(prod_mem)
                     + llws_pkg::LOAD_W'(prod_disk);
    assign overload  = (usage_rd_reg.cpu > llws_pkg::CPU_LIMIT)
                    || (usage_rd_reg.mem > llws_pkg::MEM_LIMIT)
                    || (usage_rd_reg.disk > llws_pkg::DISK_LIMIT);
    assign age       = now_reg - time_rd_reg;
    assign eligible  = slot_valid_reg[ev_idx_reg] && link_ok_reg[ev_idx_reg]
                    && usage_known_reg[ev_idx_reg]
                    && (age < llws_pkg::TIME_W'(window_reg))
                    && (usage_rd_reg.level < prio_reg);
    assign bound     = ctl.eval_desired ? max_load_reg : best_reg;
    assign cand_ok   = eligible && !overload && (load_sum < bound);

    assign sts.is_select   = (cmd_reg == llws_pkg::CMD_SELECT);
    assign sts.use_desired = des_reg && id_in_range;
    assign sts.desired_hit = cand_ok;
    assign sts.scan_last   = (scan_addr_reg == LAST_SLOT);
    assign sts.stop        = pend_valid_reg && cand_ok && (load_sum < low_load_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_weight_reg  <= llws_pkg::CPU_WEIGHT_RST;
            mem_weight_reg  <= llws_pkg::MEM_WEIGHT_RST;
            disk_weight_reg <= llws_pkg::DISK_WEIGHT_RST;
            max_load_reg    <= llws_pkg::MAX_LOAD_RST;
            low_load_reg    <= llws_pkg::LOW_LOAD_RST;
            window_reg      <= llws_pkg::WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (llws_pkg::cfg_idx_t'(cfg_index))
                llws_pkg::CFG_CPU_WEIGHT:  cpu_weight_reg  <= cfg_data[llws_pkg::WEIGHT_W-1:0];
                llws_pkg::CFG_MEM_WEIGHT:  mem_weight_reg  <= cfg_data[llws_pkg::WEIGHT_W-1:0];
                llws_pkg::CFG_DISK_WEIGHT: disk_weight_reg <= cfg_data[llws_pkg::WEIGHT_W-1:0];
                llws_pkg::CFG_MAX_LOAD:    max_load_reg    <= cfg_data[llws_pkg::LOAD_W-1:0];
                llws_pkg::CFG_LOW_LOAD:    low_load_reg    <= cfg_data[llws_pkg::LOAD_W-1:0];
                llws_pkg::CFG_WINDOW:      window_reg      <= cfg_data[llws_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg       <= llws_pkg::cmd_t'(command);
            id_reg        <= actor_id;
            des_reg       <= has_desired;
            now_reg       <= now;
            rep_reg.cpu   <= cpu_usage;
            rep_reg.mem   <= mem_usage;
            rep_reg.disk  <= disk_usage;
            rep_reg.level <= worker_level;
            prio_reg      <= priority_req;
        end
    end

    // Slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg  <= '0;
            link_ok_reg     <= '0;
            usage_known_reg <= '0;
        end
        else if (ctl.update)
        begin
            unique case (cmd_reg)
                llws_pkg::CMD_CONNECT:
                begin
                    if (id_in_range)
                    begin
                        slot_valid_reg[id_idx]  <= 1'b1;
                        link_ok_reg[id_idx]     <= 1'b1;
                        usage_known_reg[id_idx] <= 1'b0;
                    end
                end
                llws_pkg::CMD_REPORT:
                begin
                    if (present)
                    begin
                        link_ok_reg[id_idx]     <= 1'b1;
                        usage_known_reg[id_idx] <= 1'b1;
                    end
                end
                llws_pkg::CMD_DISCONNECT:
                begin
                    if (present)
                        link_ok_reg[id_idx] <= 1'b0;
                end
                llws_pkg::CMD_REMOVE:
                begin
                    if (present)
                    begin
                        slot_valid_reg[id_idx]  <= 1'b0;
                        link_ok_reg[id_idx]     <= 1'b0;
                        usage_known_reg[id_idx] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Slot memories: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ctl.update && (cmd_reg == llws_pkg::CMD_REPORT) && present)
            usage_mem[id_idx] <= rep_reg;
        if (ctl.update && (((cmd_reg == llws_pkg::CMD_CONNECT) && id_in_range)
                        || ((cmd_reg == llws_pkg::CMD_REPORT) && present)))
            time_mem[id_idx] <= now_reg;
        if (rd_en)
        begin
            usage_rd_reg <= usage_mem[rd_addr];
            time_rd_reg  <= time_mem[rd_addr];
            ev_idx_reg   <= rd_addr;
        end
    end

    // Scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= ctl.issue_scan;
            if (ctl.scan_init)
                scan_addr_reg <= '0;
            else if (ctl.issue_scan)
                scan_addr_reg <= scan_addr_reg + 1'b1;
        end
    end

    // Running best and result
    always_ff @(posedge clk)
    begin
        if (ctl.update)
        begin
            res_found_reg  <= 1'b0;
            res_actor_reg  <= '0;
            res_load_reg   <= '0;
            res_status_reg <= 1'b0;
            if ((cmd_reg == llws_pkg::CMD_REPORT) || (cmd_reg == llws_pkg::CMD_DISCONNECT)
                || (cmd_reg == llws_pkg::CMD_REMOVE))
                res_status_reg <= !present;
        end
        else if (ctl.scan_init)
        begin
            best_reg       <= max_load_reg;
            res_found_reg  <= 1'b0;
            res_actor_reg  <= '0;
            res_load_reg   <= '0;
            res_status_reg <= 1'b0;
        end
        else if ((ctl.eval_desired || (ctl.eval_scan && pend_valid_reg)) && cand_ok)
        begin
            best_reg       <= load_sum;
            res_found_reg  <= 1'b1;
            res_actor_reg  <= llws_pkg::ID_W'(ev_idx_reg);
            res_load_reg   <= load_sum;
            res_status_reg <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            found_reg  <= res_found_reg;
            actor_reg  <= res_actor_reg;
            load_reg   <= res_load_reg;
            status_reg <= res_status_reg;
        end
    end

    assign found        = found_reg;
    assign chosen_actor = actor_reg;
    assign chosen_load  = load_reg;
    assign status       = status_reg;

endmodule

/* rtl/core/llws_ctrl.sv */
// ----------------------------------------------------------------------------
// llws_ctrl: sequencing controller for the worker selector
// Steps one command through table update, desired-slot check and slot scan,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module llws_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output llws_pkg::dp_cmd_t    ctl,
    input  llws_pkg::dp_status_t sts
);

    llws_pkg::state_t state_reg;
    llws_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llws_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            llws_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = llws_pkg::ST_EXEC;
                end
            end
            llws_pkg::ST_EXEC:
            begin
                if (!sts.is_select)
                begin
                    ctl.update = 1'b1;
                    state_next = llws_pkg::ST_FINISH;
                end
                else if (sts.use_desired)
                begin
                    ctl.issue_desired = 1'b1;
                    state_next        = llws_pkg::ST_DES_EV;
                end
                else
                begin
                    ctl.scan_init = 1'b1;
                    state_next    = llws_pkg::ST_SCAN;
                end
            end
            llws_pkg::ST_DES_EV:
            begin
                ctl.eval_desired = 1'b1;
                if (sts.desired_hit)
                    state_next = llws_pkg::ST_FINISH;
                else
                begin
                    ctl.scan_init = 1'b1;
                    state_next    = llws_pkg::ST_SCAN;
                end
            end
            llws_pkg::ST_SCAN:
            begin
                ctl.issue_scan = 1'b1;
                ctl.eval_scan  = 1'b1;
                priority if (sts.stop)
                    state_next = llws_pkg::ST_FINISH;
                else if (sts.scan_last)
                    state_next = llws_pkg::ST_DRAIN;
            end
            llws_pkg::ST_DRAIN:
            begin
                ctl.eval_scan = 1'b1;
                state_next    = llws_pkg::ST_FINISH;
            end
            llws_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = llws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = llws_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken; a fresh load replaces a taken one
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    assign in_stall  = (state_reg != llws_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/least_loaded_worker_select.sv */
// ----------------------------------------------------------------------------
// least_loaded_worker_select: worker table with least-loaded selection
// Top level joining the sequencing controller and the table datapath.
// ----------------------------------------------------------------------------
// The block keeps a table of ACTOR_SLOTS worker slots and takes one command
// beat at a time: connect, usage report, disconnect, remove or select, each
// answered by exactly one result beat. A select first checks the desired
// worker if one is named. If it does not qualify, or none is named, the
// slots are scanned in index order, one slot per cycle through the single
// read port of the slot memories. A worker below low_load ends the scan
// early. A slot qualifies when its link is up, its usage is known, it
// reported within report_window seconds (time wraps modulo 2^32) and its
// level is below priority_req. Its load is the weighted usage sum, and a
// worker above 80% cpu or memory or 90% disk is never chosen. The output
// register holds a finished beat while the next command is accepted. While
// an earlier beat is still stalled at the output, the next command waits
// before its result is loaded. Configuration writes are always taken
// (cfg_ready is tied high) and must only be issued while no command is in
// flight.
// Usage and report time live in memories with no reset; an entry is used
// only once a report has written it and marked the slot's usage known.
// ----------------------------------------------------------------------------
module least_loaded_worker_select #(
    parameter int ACTOR_SLOTS = llws_pkg::ACTOR_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [llws_pkg::CMD_W-1:0]      command,
    input  logic [llws_pkg::ID_W-1:0]       actor_id,
    input  logic                            has_desired,
    input  logic [llws_pkg::TIME_W-1:0]     now,
    input  logic [llws_pkg::USAGE_W-1:0]    cpu_usage,
    input  logic [llws_pkg::USAGE_W-1:0]    mem_usage,
    input  logic [llws_pkg::USAGE_W-1:0]    disk_usage,
    input  logic [llws_pkg::LEVEL_W-1:0]    worker_level,
    input  logic [llws_pkg::LEVEL_W-1:0]    priority_req,
    // Result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [llws_pkg::ID_W-1:0]       chosen_actor,
    output logic [llws_pkg::LOAD_W-1:0]     chosen_load,
    output logic                            status,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [llws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [llws_pkg::CFG_DATA_W-1:0] cfg_data
);

    llws_pkg::dp_cmd_t    ctl;
    llws_pkg::dp_status_t sts;

    // Take every configuration beat; registers sit in the datapath
    assign cfg_ready = 1'b1;

    llws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    llws_dp #(
        .ACTOR_SLOTS (ACTOR_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .command      (command),
        .actor_id     (actor_id),
        .has_desired  (has_desired),
        .now          (now),
        .cpu_usage    (cpu_usage),
        .mem_usage    (mem_usage),
        .disk_usage   (disk_usage),
        .worker_level (worker_level),
        .priority_req (priority_req),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .found        (found),
        .chosen_actor (chosen_actor),
        .chosen_load  (chosen_load),
        .status       (status)
    );

endmodule

/* tb/tb_least_loaded_worker_select.sv */
// ----------------------------------------------------------------------------
// tb_least_loaded_worker_select: self-checking bench for the worker selector
// Drives connect, report, disconnect, remove and select beats with random
// gaps and result back-pressure, predicts every result beat from a local copy
// of the worker table and compares each returned beat field by field.
// ----------------------------------------------------------------------------
module tb_least_loaded_worker_select;
    import llws_pkg::*;

    localparam int SLOTS = ACTOR_SLOTS_DEF;

    // Command codes the block does not define; they must leave the table alone
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Load given to an overloaded worker; never below any max_load
    localparam logic [31:0] OVERLOAD_LOAD = 32'h00FF_FFFF;

    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 163;
    // Margin to wait after draining before the final check
    localparam int TAIL_CYCLES  = 2 * (SLOTS + 5);

    // One command beat as presented on the input channel
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    id;
        logic               desired;
        logic [TIME_W-1:0]  now;
        logic [USAGE_W-1:0] cpu;
        logic [USAGE_W-1:0] mem;
        logic [USAGE_W-1:0] disk;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] prio;
    } cmd_beat_t;

    // One result beat
    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   actor;
        logic [LOAD_W-1:0] load;
        logic              status;
    } answer_t;

    // ------------------------------------------------------------------------
    // Worker table mirror: applies each accepted command beat to its own copy
    // of the table and registers, queues the answer it predicts, and checks
    // returned answers against the oldest queued one.
    // ------------------------------------------------------------------------
    class selection_tracker;
        logic [WEIGHT_W-1:0] w_cpu;
        logic [WEIGHT_W-1:0] w_mem;
        logic [WEIGHT_W-1:0] w_disk;
        logic [LOAD_W-1:0]   max_load;
        logic [LOAD_W-1:0]   low_load;
        logic [WINDOW_W-1:0] report_window;

        bit                 present     [SLOTS];
        bit                 link_up     [SLOTS];
        bit                 usage_valid [SLOTS];
        logic [USAGE_W-1:0] cpu         [SLOTS];
        logic [USAGE_W-1:0] mem         [SLOTS];
        logic [USAGE_W-1:0] disk        [SLOTS];
        logic [LEVEL_W-1:0] level       [SLOTS];
        logic [TIME_W-1:0]  reported_at [SLOTS];

        answer_t pending_answers[$];
        int      mismatches;
        int      answers_seen;

        function new();
            w_cpu         = CPU_WEIGHT_RST;
            w_mem         = MEM_WEIGHT_RST;
            w_disk        = DISK_WEIGHT_RST;
            max_load      = MAX_LOAD_RST;
            low_load      = LOW_LOAD_RST;
            report_window = WINDOW_RST;
            for (int s = 0; s < SLOTS; s++)
            begin
                present[s]     = 1'b0;
                link_up[s]     = 1'b0;
                usage_valid[s] = 1'b0;
                cpu[s]         = '0;
                mem[s]         = '0;
                disk[s]        = '0;
                level[s]       = '0;
                reported_at[s] = '0;
            end
            mismatches   = 0;
            answers_seen = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_CPU_WEIGHT:  w_cpu         = d[WEIGHT_W-1:0];
                CFG_MEM_WEIGHT:  w_mem         = d[WEIGHT_W-1:0];
                CFG_DISK_WEIGHT: w_disk        = d[WEIGHT_W-1:0];
                CFG_MAX_LOAD:    max_load      = d[LOAD_W-1:0];
                CFG_LOW_LOAD:    low_load      = d[LOAD_W-1:0];
                CFG_WINDOW:      report_window = d[WINDOW_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] slot_load(int s);
            if (cpu[s] > CPU_LIMIT || mem[s] > MEM_LIMIT || disk[s] > DISK_LIMIT)
                return OVERLOAD_LOAD;
            return 32'(cpu[s]) * 32'(w_cpu) + 32'(mem[s]) * 32'(w_mem)
                 + 32'(disk[s]) * 32'(w_disk);
        endfunction

        // Age is taken modulo 2^32 so that a report just before the wrap
        // stays fresh just after it
        function bit qualifies(int s, logic [TIME_W-1:0] t, logic [LEVEL_W-1:0] prio);
            logic [TIME_W-1:0] age;
            age = t - reported_at[s];
            return present[s] && link_up[s] && usage_valid[s]
                && age < TIME_W'(report_window) && level[s] < prio;
        endfunction

        function void note_command(cmd_beat_t b);
            answer_t     a;
            bit          done;
            logic [31:0] best;
            logic [31:0] l;
            a    = '0;
            done = 1'b0;
            case (b.cmd)
                CMD_CONNECT:
                begin
                    present[b.id]     = 1'b1;
                    link_up[b.id]     = 1'b1;
                    usage_valid[b.id] = 1'b0;
                    reported_at[b.id] = b.now;
                end
                CMD_REPORT:
                begin
                    if (present[b.id])
                    begin
                        link_up[b.id]     = 1'b1;
                        usage_valid[b.id] = 1'b1;
                        cpu[b.id]         = b.cpu;
                        mem[b.id]         = b.mem;
                        disk[b.id]        = b.disk;
                        level[b.id]       = b.level;
                        reported_at[b.id] = b.now;
                    end
                    else
                    begin
                        a.status = 1'b1;
                    end
                end
                CMD_DISCONNECT:
                begin
                    if (present[b.id]) link_up[b.id] = 1'b0;
                    else a.status = 1'b1;
                end
                CMD_REMOVE:
                begin
                    if (present[b.id])
                    begin
                        present[b.id]     = 1'b0;
                        link_up[b.id]     = 1'b0;
                        usage_valid[b.id] = 1'b0;
                    end
                    else
                    begin
                        a.status = 1'b1;
                    end
                end
                CMD_SELECT:
                begin
                    // Try the desired worker first
                    if (b.desired && qualifies(int'(b.id), b.now, b.prio))
                    begin
                        l = slot_load(int'(b.id));
                        if (l < 32'(max_load))
                        begin
                            a.found = 1'b1;
                            a.actor = b.id;
                            a.load  = l[LOAD_W-1:0];
                            done    = 1'b1;
                        end
                    end
                    // Otherwise scan upward, keeping the strict minimum;
                    // stop at the first best load below low_load
                    if (!done)
                    begin
                        best = 32'(max_load);
                        for (int s = 0; s < SLOTS && !done; s++)
                        begin
                            if (qualifies(s, b.now, b.prio))
                            begin
                                l = slot_load(s);
                                if (l < best)
                                begin
                                    best    = l;
                                    a.found = 1'b1;
                                    a.actor = ID_W'(s);
                                    a.load  = l[LOAD_W-1:0];
                                    if (l < 32'(low_load)) done = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            pending_answers = {pending_answers, a};
        endfunction

        task report_mismatch(string what);
            $display("ERROR result beat %0d: %s", answers_seen, what);
            mismatches++;
        endtask

        task check_answer(answer_t got);
            answer_t want;
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                report_mismatch("result beat with no command outstanding");
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %b, want %b", got.found, want.found));
            if (got.actor !== want.actor)
                report_mismatch($sformatf("chosen_actor %0d, want %0d",
                                          got.actor, want.actor));
            if (got.load !== want.load)
                report_mismatch($sformatf("chosen_load %0d, want %0d",
                                          got.load, want.load));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %b, want %b", got.status, want.status));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals and the block itself
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                  in_valid;
    logic                  in_stall;
    logic [CMD_W-1:0]      command;
    logic [ID_W-1:0]       actor_id;
    logic                  has_desired;
    logic [TIME_W-1:0]     now;
    logic [USAGE_W-1:0]    cpu_usage;
    logic [USAGE_W-1:0]    mem_usage;
    logic [USAGE_W-1:0]    disk_usage;
    logic [LEVEL_W-1:0]    worker_level;
    logic [LEVEL_W-1:0]    priority_req;

    logic                  out_valid;
    logic                  out_stall;
    logic                  found;
    logic [ID_W-1:0]       chosen_actor;
    logic [LOAD_W-1:0]     chosen_load;
    logic                  status;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    selection_tracker tracker;

    // Set for the final phase: no gaps and no back-pressure from then on
    bit no_idle = 1'b0;

    // Running wall clock for well-formed random traffic
    logic [TIME_W-1:0] wall_s;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    least_loaded_worker_select #(
        .ACTOR_SLOTS (SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .actor_id     (actor_id),
        .has_desired  (has_desired),
        .now          (now),
        .cpu_usage    (cpu_usage),
        .mem_usage    (mem_usage),
        .disk_usage   (disk_usage),
        .worker_level (worker_level),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .chosen_actor (chosen_actor),
        .chosen_load  (chosen_load),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------------
    function automatic cmd_beat_t beat_of(logic [CMD_W-1:0] cmd, int id, bit desired,
                                          logic [TIME_W-1:0] t, int c, int m, int d,
                                          int lvl, int prio);
        cmd_beat_t b;
        b.cmd     = cmd;
        b.id      = ID_W'(id);
        b.desired = desired;
        b.now     = t;
        b.cpu     = USAGE_W'(c);
        b.mem     = USAGE_W'(m);
        b.disk    = USAGE_W'(d);
        b.level   = LEVEL_W'(lvl);
        b.prio    = LEVEL_W'(prio);
        return b;
    endfunction

    // Mostly healthy usage so that selects have real candidates; the rest
    // spans the full percent range and so hits the overload limits
    function automatic logic [USAGE_W-1:0] random_usage();
        if ($urandom_range(0, 3) != 0)
            return USAGE_W'($urandom_range(0, 60));
        return USAGE_W'($urandom_range(0, 100));
    endfunction

    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        int        pick;
        b.id      = ID_W'($urandom_range(0, SLOTS - 1));
        b.desired = 1'($urandom_range(0, 1));
        b.cpu     = random_usage();
        b.mem     = random_usage();
        b.disk    = random_usage();
        b.level   = LEVEL_W'($urandom_range(0, 7));
        b.prio    = LEVEL_W'($urandom_range(0, 7));
        // Advance the wall clock slowly, with the odd jump that turns
        // workers stale; a few beats carry an arbitrary time as noise
        wall_s = wall_s + $urandom_range(0, 2);
        if ($urandom_range(0, 19) == 0)
            wall_s = wall_s + $urandom_range(3, 40);
        b.now = wall_s;
        if ($urandom_range(0, 24) == 0)
            b.now = $urandom;
        pick = int'($urandom_range(0, 99));
        if (pick < 12)
            b.cmd = CMD_CONNECT;
        else if (pick < 47)
            b.cmd = CMD_REPORT;
        else if (pick < 53)
            b.cmd = CMD_DISCONNECT;
        else if (pick < 58)
            b.cmd = CMD_REMOVE;
        else if (pick < 98)
            b.cmd = CMD_SELECT;
        else
            b.cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Present one command beat and hold it until the block takes it. Valid
    // stays high on return; the caller either sends the next beat at once or
    // drops valid through a gap or a drain.
    task automatic send_beat(cmd_beat_t b);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= b.cmd;
        actor_id     <= b.id;
        has_desired  <= b.desired;
        now          <= b.now;
        cpu_usage    <= b.cpu;
        mem_usage    <= b.mem;
        disk_usage   <= b.disk;
        worker_level <= b.level;
        priority_req <= b.prio;
        do @(posedge clk); while (in_stall);
        tracker.note_command(b);
    endtask

    // Drop valid and hold off until every predicted result beat has returned
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending_answers.size() != 0) @(posedge clk);
    endtask

    // Write all six registers back to back; only called with the block idle
    task automatic write_settings(int wc, int wm, int wd, int mx, int lo, int win);
        logic [CFG_DATA_W-1:0] vals [6];
        cfg_idx_t              idx;
        vals[0] = CFG_DATA_W'(wc);
        vals[1] = CFG_DATA_W'(wm);
        vals[2] = CFG_DATA_W'(wd);
        vals[3] = CFG_DATA_W'(mx);
        vals[4] = CFG_DATA_W'(lo);
        vals[5] = CFG_DATA_W'(win);
        for (int i = 0; i < 6; i++)
        begin
            idx = cfg_idx_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            tracker.set_register(idx, vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: check every accepted result beat, and stall in random
    // bursts until the final phase
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int      hold;
        answer_t got;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.found  = found;
                got.actor  = chosen_actor;
                got.load   = chosen_load;
                got.status = status;
                tracker.check_answer(got);
            end
            if (hold != 0 && !no_idle)
            begin
                out_stall <= 1'b1;
                hold = hold - 1;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                hold = int'($urandom_range(0, 7));
            end
            else
            begin
                out_stall <= 1'b0;
                hold = 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int mx;
        tracker = new();

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_CONNECT;
        actor_id     = '0;
        has_desired  = 1'b0;
        now          = '0;
        cpu_usage    = '0;
        mem_usage    = '0;
        disk_usage   = '0;
        worker_level = '0;
        priority_req = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_CPU_WEIGHT;
        cfg_data     = '0;
        wall_s       = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset register values: weights 1/1/0,
        // max_load 160, low_load 40, window 10 s.

        // Empty table: nothing to choose, and every addressed command misses
        send_beat(beat_of(CMD_SELECT, 15, 1'b1, 32'd100, 0, 0, 0, 0, 7));
        send_beat(beat_of(CMD_REPORT, 3, 1'b0, 32'd100, 5, 5, 5, 1, 0));
        send_beat(beat_of(CMD_DISCONNECT, 3, 1'b0, 32'd100, 0, 0, 0, 0, 0));
        send_beat(beat_of(CMD_REMOVE, 3, 1'b0, 32'd100, 0, 0, 0, 0, 0));
        // Connected but usage not yet known: not eligible
        send_beat(beat_of(CMD_CONNECT, 0, 1'b0, 32'd100, 0, 0, 0, 0, 0));
        send_beat(beat_of(CMD_SELECT, 0, 1'b1, 32'd100, 0, 0, 0, 0, 7));
        // Full usage and top level: overloaded and level not below priority
        send_beat(beat_of(CMD_REPORT, 0, 1'b0, 32'd100, 100, 100, 100, 7, 0));
        send_beat(beat_of(CMD_SELECT, 0, 1'b1, 32'd100, 0, 0, 0, 0, 7));
        // Idle worker at level 0: a priority of 0 admits nobody
        send_beat(beat_of(CMD_REPORT, 0, 1'b0, 32'd101, 0, 0, 0, 0, 0));
        send_beat(beat_of(CMD_SELECT, 0, 1'b0, 32'd101, 0, 0, 0, 0, 0));
        send_beat(beat_of(CMD_SELECT, 0, 1'b0, 32'd101, 0, 0, 0, 0, 7));
        // Worker at the last time value, right on the cpu and disk limits
        send_beat(beat_of(CMD_CONNECT, 15, 1'b0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        send_beat(beat_of(CMD_REPORT, 15, 1'b0, 32'hFFFF_FFFF, 80, 79, 90, 3, 0));
        send_beat(beat_of(CMD_CONNECT, 5, 1'b0, 32'd100, 0, 0, 0, 0, 0));
        send_beat(beat_of(CMD_REPORT, 5, 1'b0, 32'd100, 20, 10, 50, 2, 0));
        // Desired worker still fresh across the time wrap
        send_beat(beat_of(CMD_SELECT, 15, 1'b1, 32'd5, 0, 0, 0, 0, 4));
        // Plain scan: slot 0 is below low_load and ends it
        send_beat(beat_of(CMD_SELECT, 9, 1'b0, 32'd105, 0, 0, 0, 0, 7));
        // Link down on slot 0: the scan falls through to slot 5
        send_beat(beat_of(CMD_DISCONNECT, 0, 1'b0, 32'd105, 0, 0, 0, 0, 0));
        send_beat(beat_of(CMD_SELECT, 9, 1'b0, 32'd105, 0, 0, 0, 0, 7));
        // A report brings the link back; desired slot 5 at the window edge
        send_beat(beat_of(CMD_REPORT, 0, 1'b0, 32'd106, 10, 10, 10, 1, 0));
        send_beat(beat_of(CMD_SELECT, 5, 1'b1, 32'd109, 0, 0, 0, 0, 7));
        send_beat(beat_of(CMD_SELECT, 5, 1'b1, 32'd110, 0, 0, 0, 0, 7));
        // Remove, then the undefined command codes, then a reconnect that
        // forgets the usage
        send_beat(beat_of(CMD_REMOVE, 5, 1'b0, 32'd110, 0, 0, 0, 0, 0));
        for (int c = int'(CMD_SPARE_LO); c <= int'(CMD_SPARE_HI); c++)
            send_beat(beat_of(CMD_W'(c), 0, 1'b1, 32'd110, 30, 30, 30, 0, 7));
        send_beat(beat_of(CMD_CONNECT, 0, 1'b0, 32'd111, 0, 0, 0, 0, 0));
        send_beat(beat_of(CMD_SELECT, 0, 1'b1, 32'd111, 0, 0, 0, 0, 7));

        // Random phases, each under its own register settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            repeat (2) @(posedge clk);
            case (phase)
                0: write_settings(15, 15, 15, 8191, 8191, 255);
                1: write_settings(0, 0, 0, 0, 0, 1);
                2: write_settings(15, 15, 15, 8191, 0, 255);
                3: write_settings(1, 1, 0, 160, 40, 10);
                default:
                begin
                    mx = int'($urandom_range(20, 3000));
                    write_settings(int'($urandom_range(0, 15)), int'($urandom_range(0, 15)),
                                   int'($urandom_range(0, 15)), mx,
                                   int'($urandom_range(0, mx)),
                                   int'($urandom_range(1, 40)));
                end
            endcase
            if (phase == PHASES - 1)
                no_idle = 1'b1;
            // Every third phase runs across the 2^32 wrap
            if (phase % 3 == 1)
                wall_s = 32'hFFFF_FFC0;
            else
                wall_s = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold off mid-phase once until the block has emptied
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_beat(random_beat());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure
    initial
    begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
